>>> hdl/mu8d_pkg.sv
// shared types and constants of the modified utf-8 decoder
package mu8d_pkg;

    // depth of the queue between front and back
    localparam int MU8D_QDEPTH = 4;
    localparam int MU8D_QPTR_W = $clog2(MU8D_QDEPTH);
    localparam int MU8D_QCNT_W = $clog2(MU8D_QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } mu8d_status_t;

    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_CONT  = 3'd3,
        CLS_BAD   = 3'd4
    } mu8d_class_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } mu8d_in_t;

    typedef struct packed {
        logic [15:0]  code_unit;
        mu8d_status_t status;
        logic         is_last;
        logic         has_char;
    } mu8d_out_t;

    // classified byte as it travels through the queue
    typedef struct packed {
        mu8d_class_t cls;
        logic [7:0]  byte_in;
        logic        final_byte;
    } mu8d_item_t;

endpackage

>>> hdl/mu8d_front.sv
// front stage: accepts input beats and classifies each byte
module mu8d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mu8d_pkg::mu8d_in_t  s_data,
    output logic                f_valid,
    input  logic                f_ready,
    output mu8d_pkg::mu8d_item_t f_item
);

    logic                 f_valid_reg;
    logic                 f_valid_next;
    mu8d_pkg::mu8d_item_t f_item_reg;
    mu8d_pkg::mu8d_class_t cls;

    always_comb begin
        if (s_data.byte_in[7] == 1'b0) begin
            cls = mu8d_pkg::CLS_ASCII;
        end else if (s_data.byte_in[7:5] == 3'b110) begin
            cls = mu8d_pkg::CLS_LEAD2;
        end else if (s_data.byte_in[7:4] == 4'b1110) begin
            cls = mu8d_pkg::CLS_LEAD3;
        end else if (s_data.byte_in[7:6] == 2'b10) begin
            cls = mu8d_pkg::CLS_CONT;
        end else begin
            cls = mu8d_pkg::CLS_BAD;
        end
    end

    assign s_ready = !f_valid_reg || f_ready;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_ready) begin
            f_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (s_valid && s_ready) begin
            f_item_reg.cls        <= cls;
            f_item_reg.byte_in    <= s_data.byte_in;
            f_item_reg.final_byte <= s_data.final_byte;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_item  = f_item_reg;

endmodule

>>> hdl/mu8d_queue.sv
// short fifo between the classifying front and the decoding back
module mu8d_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  mu8d_pkg::mu8d_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output mu8d_pkg::mu8d_item_t rd_item
);

    mu8d_pkg::mu8d_item_t mem [mu8d_pkg::MU8D_QDEPTH];

    logic [mu8d_pkg::MU8D_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mu8d_pkg::MU8D_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mu8d_pkg::MU8D_QCNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign wr_ready = (count_reg != mu8d_pkg::MU8D_QCNT_W'(mu8d_pkg::MU8D_QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == mu8d_pkg::MU8D_QPTR_W'(mu8d_pkg::MU8D_QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == mu8d_pkg::MU8D_QPTR_W'(mu8d_pkg::MU8D_QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mu8d_pkg::MU8D_QCNT_W'(mu8d_pkg::MU8D_QDEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == mu8d_pkg::MU8D_QCNT_W'(mu8d_pkg::MU8D_QDEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

>>> hdl/mu8d_back.sv
// back stage: decode state machine and output register
module mu8d_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  mu8d_pkg::mu8d_item_t q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mu8d_pkg::mu8d_out_t  m_data
);

    logic [1:0]  pending_reg, pending_next;
    logic [9:0]  partial_reg, partial_next;
    logic        skip_reg, skip_next;
    logic        m_valid_reg, m_valid_next;
    mu8d_pkg::mu8d_out_t out_reg;
    mu8d_pkg::mu8d_out_t res;
    logic        emit;
    logic        pop;
    logic        last;
    logic [15:0] value;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;
    assign last    = q_item.final_byte;
    assign value   = {partial_reg, q_item.byte_in[5:0]};

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        res.code_unit = '0;
        res.status    = mu8d_pkg::ST_OK;
        res.is_last   = last;
        res.has_char  = 1'b0;

        if (skip_reg) begin
            emit = last;
        end else if (pending_reg == 2'd0) begin
            case (q_item.cls)
                mu8d_pkg::CLS_ASCII: begin
                    emit          = 1'b1;
                    res.code_unit = {9'd0, q_item.byte_in[6:0]};
                    res.has_char  = 1'b1;
                end
                mu8d_pkg::CLS_LEAD2: begin
                    if (last) begin
                        emit       = 1'b1;
                        res.status = mu8d_pkg::ST_TRUNC;
                    end else begin
                        pending_next = 2'd1;
                        partial_next = {5'd0, q_item.byte_in[4:0]};
                    end
                end
                mu8d_pkg::CLS_LEAD3: begin
                    if (last) begin
                        emit       = 1'b1;
                        res.status = mu8d_pkg::ST_TRUNC;
                    end else begin
                        pending_next = 2'd2;
                        partial_next = {6'd0, q_item.byte_in[3:0]};
                    end
                end
                default: begin
                    emit       = 1'b1;
                    res.status = mu8d_pkg::ST_BAD_LEAD;
                    skip_next  = 1'b1;
                end
            endcase
        end else if (q_item.cls != mu8d_pkg::CLS_CONT) begin
            emit         = 1'b1;
            res.status   = mu8d_pkg::ST_BAD_CONT;
            skip_next    = 1'b1;
            pending_next = 2'd0;
            partial_next = '0;
        end else if (pending_reg == 2'd1) begin
            emit          = 1'b1;
            res.code_unit = value;
            res.has_char  = 1'b1;
            pending_next  = 2'd0;
            partial_next  = '0;
        end else if (last) begin
            emit       = 1'b1;
            res.status = mu8d_pkg::ST_TRUNC;
        end else begin
            pending_next = pending_reg - 2'd1;
            partial_next = value[9:0];
        end

        // the final byte always returns the sequence state to reset
        if (last) begin
            pending_next = 2'd0;
            partial_next = '0;
            skip_next    = 1'b0;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (pop && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                skip_reg    <= skip_next;
            end
        end
        if (pop && emit) begin
            out_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("pending count out of range");

    a_skip_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> pending_reg == 2'd0 && partial_reg == '0)
        else $error("sequence state held while skipping");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && last |=> pending_reg == 2'd0 && !skip_reg && partial_reg == '0)
        else $error("state not cleared after final byte");

    a_char_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.status != mu8d_pkg::ST_OK
        |-> !out_reg.has_char && out_reg.code_unit == '0)
        else $error("error beat carries a character");

endmodule

>>> hdl/modified_utf8_decoder.sv
// top level of the modified utf-8 decoder: front, queue and back
// path: a byte is registered in the front, written into the queue, then decoded into the registered output beat
// throughput: one byte per cycle while the output is not stalled; the back stage decodes each byte combinationally
// a byte that only opens or continues a sequence gives no beat on the output
// reset: synchronous active-low aresetn clears the decode state, queue and valid flags
// there is no clearing pass; the block takes beats from the first cycle after reset
module modified_utf8_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    // byte input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  mu8d_pkg::mu8d_in_t  s_data,
    // code unit output channel
    output logic                m_valid,
    input  logic                m_ready,
    output mu8d_pkg::mu8d_out_t m_data
);

    // front to queue
    logic                 f_valid;
    logic                 f_ready;
    mu8d_pkg::mu8d_item_t f_item;

    // queue to back
    logic                 q_valid;
    logic                 q_ready;
    mu8d_pkg::mu8d_item_t q_item;

    // front: registers each beat with its byte class
    mu8d_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_item  (f_item)
    );

    // short queue so an output stall does not stop the input at once
    mu8d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // back: sequence state and the registered output beat
    mu8d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/tb_modified_utf8_decoder.sv
// self-checking testbench for the modified utf-8 decoder: byte beats in, code unit beats out
module tb_modified_utf8_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // ways a generated string gets damaged on purpose
    typedef enum int {
        MANGLE_NONE,
        MANGLE_REPLACE,
        MANGLE_CUT,
        MANGLE_NOISE
    } mangle_t;

    // four idling phases: sender idle and receiver stall, in percent
    localparam int NUM_PHASES = 4;
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 86, 0, 34};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 86, 34};
    localparam int PHASE_BYTES    = 440;
    localparam int PRESSURE_BYTES = 120;
    localparam int HOLD_CYCLES    = 400;
    // idle time before the final verdict, once everything has drained
    localparam int DRAIN_CYCLES   = 10;

    // directed beats: bit 8 marks the final byte of a string, bits 7:0 the byte
    localparam int NUM_DIRECTED = 25;
    localparam logic [8:0] DIRECTED_BEATS [NUM_DIRECTED] = '{
        // ascii extremes, overlong nul, top two-byte and three-byte values
        9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h141,
        // three-byte overlong zero ending the string
        9'h0E0, 9'h080, 9'h180,
        // stray continuation as lead, then skipped bytes and a bare end marker
        9'h080, 9'h055, 9'h123,
        // 1111xxxx lead on the final byte
        9'h1FF,
        // bad continuation landing on the final byte
        9'h0C2, 9'h141,
        // strings cut short: a lone two-byte lead, a three-byte lead plus one continuation
        9'h1C3, 9'h0E1, 9'h180,
        // bad continuation mid-string, then the end marker
        9'h0E2, 9'h0F0, 9'h100
    };

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mu8d_pkg::mu8d_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mu8d_pkg::mu8d_out_t m_data;

    modified_utf8_decoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // bytes waiting to be offered, and code units the decoder owes us
    mu8d_pkg::mu8d_in_t  pending_bytes[$];
    mu8d_pkg::mu8d_out_t expected_units[$];

    // decode state of our own copy of the decoder
    logic [1:0] dec_pending = '0;
    logic [9:0] dec_partial = '0;
    logic       dec_skip    = 1'b0;

    // knobs set by the stimulus process at falling edges
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    // receiver hold-off bookkeeping, owned by the ready process
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    int error_count    = 0;
    int bytes_accepted = 0;
    int units_checked  = 0;
    int chars_seen     = 0;
    int strings_sent   = 0;
    int input_stalls   = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    // next decoder step for one byte beat; returns 1 when a code unit beat is due
    function automatic bit decode_byte(input mu8d_pkg::mu8d_in_t beat,
                                       output mu8d_pkg::mu8d_out_t unit);
        logic [7:0]  b;
        logic [15:0] joined;
        b = beat.byte_in;
        unit = '0;
        unit.status  = mu8d_pkg::ST_OK;
        unit.is_last = beat.final_byte;

        // after an error only the final byte matters: bare end marker
        if (dec_skip) begin
            if (!beat.final_byte)
                return 1'b0;
            dec_skip = 1'b0;
            return 1'b1;
        end

        if (dec_pending == 2'd0) begin
            if (!b[7]) begin
                unit.code_unit = {8'h00, b};
                unit.has_char  = 1'b1;
                return 1'b1;
            end
            if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
                // a lead on the final byte can never complete
                if (beat.final_byte) begin
                    unit.status = mu8d_pkg::ST_TRUNC;
                    return 1'b1;
                end
                dec_pending = b[5] ? 2'd2 : 2'd1;
                dec_partial = b[5] ? {6'd0, b[3:0]} : {5'd0, b[4:0]};
                return 1'b0;
            end
            // continuation byte or 1111xxxx where a lead belongs
            unit.status = mu8d_pkg::ST_BAD_LEAD;
            dec_skip    = !beat.final_byte;
            return 1'b1;
        end

        if (b[7:6] != 2'b10) begin
            unit.status = mu8d_pkg::ST_BAD_CONT;
            dec_pending = 2'd0;
            dec_partial = '0;
            dec_skip    = !beat.final_byte;
            return 1'b1;
        end

        joined      = {dec_partial, b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0) begin
            dec_partial    = '0;
            unit.code_unit = joined;
            unit.has_char  = 1'b1;
            return 1'b1;
        end
        if (beat.final_byte) begin
            // valid continuation but the sequence is still open
            dec_pending    = 2'd0;
            dec_partial    = '0;
            unit.status    = mu8d_pkg::ST_TRUNC;
            return 1'b1;
        end
        dec_partial = joined[9:0];
        return 1'b0;
    endfunction

    task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
        error_count++;
        $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, field, want, got);
    endtask

    // queue one random string; returns the number of bytes queued
    task automatic queue_string(input mangle_t how, output int queued);
        logic [7:0]         bytes[$];
        logic [15:0]        cu;
        int                 nchars;
        int                 cut_len;
        mu8d_pkg::mu8d_in_t beat;
        nchars = $urandom_range(12, 1);
        for (int i = 0; i < nchars; i++) begin
            cu = 16'($urandom);
            case ($urandom_range(2))
                0: begin
                    bytes.push_back({1'b0, cu[6:0]});
                end
                1: begin
                    bytes.push_back({3'b110, cu[10:6]});
                    bytes.push_back({2'b10, cu[5:0]});
                end
                default: begin
                    bytes.push_back({4'b1110, cu[15:12]});
                    bytes.push_back({2'b10, cu[11:6]});
                    bytes.push_back({2'b10, cu[5:0]});
                end
            endcase
        end
        case (how)
            MANGLE_REPLACE: begin
                bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom);
            end
            MANGLE_CUT: begin
                // often stops inside a multi-byte sequence
                cut_len = $urandom_range(bytes.size(), 1);
                while (bytes.size() > cut_len)
                    void'(bytes.pop_back());
            end
            MANGLE_NOISE: begin
                bytes.delete();
                repeat ($urandom_range(6, 1))
                    bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (bytes[i]) begin
            beat.byte_in    = bytes[i];
            beat.final_byte = (i == bytes.size() - 1);
            pending_bytes.push_back(beat);
        end
        strings_sent++;
        queued = bytes.size();
    endtask

    // mostly well-formed strings, with a share of damaged ones and noise unless clean_only
    task automatic queue_phase(input int target, input bit clean_only);
        int      filled;
        int      n;
        int      roll;
        mangle_t how;
        filled = 0;
        while (filled < target) begin
            roll = $urandom_range(99);
            if (clean_only || roll < 78)
                how = MANGLE_NONE;
            else if (roll < 86)
                how = MANGLE_REPLACE;
            else if (roll < 94)
                how = MANGLE_CUT;
            else
                how = MANGLE_NOISE;
            queue_string(how, n);
            // pure noise mostly lands in skipped bytes, so it does not count
            if (how != MANGLE_NOISE)
                filled += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_units.size() != 0)
            @(negedge aclk);
    endtask

    // sender: offers queued bytes, predicts on every accepted beat
    always @(posedge aclk) begin : drive_bytes
        mu8d_pkg::mu8d_out_t unit;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_data      <= '0;
            dec_pending = '0;
            dec_partial = '0;
            dec_skip    = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bytes_accepted++;
                if (decode_byte(s_data, unit))
                    expected_units.push_back(unit);
            end
            if (s_valid && !s_ready)
                input_stalls++;
            // payload only moves once the current beat has gone
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (!hold_req)
                hold_taken <= 1'b0;
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // checker: every output beat against the oldest expected code unit
    always @(posedge aclk) begin : check_units
        mu8d_pkg::mu8d_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, nothing expected, got %p", $time, m_data);
            end else begin
                want = expected_units.pop_front();
                units_checked++;
                status_seen[want.status]++;
                if (want.has_char)
                    chars_seen++;
                if (m_data.code_unit !== want.code_unit)
                    flag_field("code_unit", want.code_unit, m_data.code_unit);
                if (m_data.status !== want.status)
                    flag_field("status", want.status, m_data.status);
                if (m_data.is_last !== want.is_last)
                    flag_field("is_last", want.is_last, m_data.is_last);
                if (m_data.has_char !== want.has_char)
                    flag_field("has_char", want.has_char, m_data.has_char);
            end
        end
    end

    initial begin : stimulus
        mu8d_pkg::mu8d_in_t beat;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed strings first, no idling
        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        foreach (DIRECTED_BEATS[i]) begin
            beat.byte_in    = DIRECTED_BEATS[i][7:0];
            beat.final_byte = DIRECTED_BEATS[i][8];
            pending_bytes.push_back(beat);
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            @(negedge aclk);
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            queue_phase(PHASE_BYTES, 1'b0);
            wait_drained();

            // after the unthrottled phase: hold the receiver off while bytes keep coming
            if (p == 0) begin
                @(negedge aclk);
                hold_req = 1'b1;
                queue_phase(PRESSURE_BYTES, 1'b1);
                wait_drained();
                @(negedge aclk);
                hold_req = 1'b0;
            end
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("summary: %0d strings, %0d bytes in, %0d beats out, %0d characters",
                 strings_sent, bytes_accepted, units_checked, chars_seen);
        $display("summary: ok %0d, bad lead %0d, bad cont %0d, truncated %0d, input stalls %0d",
                 status_seen[mu8d_pkg::ST_OK], status_seen[mu8d_pkg::ST_BAD_LEAD],
                 status_seen[mu8d_pkg::ST_BAD_CONT], status_seen[mu8d_pkg::ST_TRUNC],
                 input_stalls);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, several times the slowest expected run
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/mu8d_pkg.sv
hdl/mu8d_front.sv
hdl/mu8d_queue.sv
hdl/mu8d_back.sv
hdl/modified_utf8_decoder.sv
tb/tb_modified_utf8_decoder.sv
